// ----- rtl/core/catmull_rom_point_eval_macros.svh -----
// Assertion helpers shared by the spline pipeline.
// Each expects clk and arst_n in the scope where it is used.
`ifndef CATMULL_ROM_POINT_EVAL_MACROS_SVH
`define CATMULL_ROM_POINT_EVAL_MACROS_SVH

// Same-cycle implication.
`define CRPE_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Implication checked in the next cycle.
`define CRPE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/core/crpe_pkg.sv -----
`timescale 1ns / 1ps
package crpe_pkg;

	// Field widths
	localparam int COORD_W = 16;
	localparam int T_FRAC  = 16;
	localparam int T_W     = T_FRAC + 1;

	// Polynomial coefficient widths (cubic and quadratic share one)
	localparam int COEF_W  = COORD_W + 4;
	localparam int CB_W    = COORD_W + 1;
	localparam int CA_W    = COORD_W + 1;

	// Horner accumulator: multiplicand width, split into two partial products
	localparam int MUL_W   = COORD_W + 2 * T_FRAC + 8;
	localparam int LO_W    = MUL_W / 2;
	localparam int HI_W    = MUL_W - LO_W;
	localparam int PROD_W  = MUL_W + T_FRAC;

	// Final scaling: three powers of t plus the factor of one half
	localparam int SHIFT   = 3 * T_FRAC + 1;
	localparam int RND_W   = PROD_W - SHIFT;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic        [T_W-1:0]     tpar_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [CB_W-1:0]    cb_t;
	typedef logic signed [CA_W-1:0]    ca_t;
	typedef logic signed [MUL_W-1:0]   mul_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	localparam tpar_t  T_ONE     = {1'b1, {T_FRAC{1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// Input beat: four control points and the curve parameter
	typedef struct packed {
		coord_t p0_x;
		coord_t p0_y;
		coord_t p1_x;
		coord_t p1_y;
		coord_t p2_x;
		coord_t p2_y;
		coord_t p3_x;
		coord_t p3_y;
		tpar_t  param_t;
	} knots_t;

	// Output beat
	typedef struct packed {
		coord_t curve_x;
		coord_t curve_y;
		logic   saturated;
	} curve_t;

	// Carried alongside the accumulators: clamped t and the later addends.
	// ca holds 2*P1 + 1, the extra one being the rounding half.
	typedef struct packed {
		tpar_t t;
		cb_t   cb_x;
		cb_t   cb_y;
		ca_t   ca_x;
		ca_t   ca_y;
	} side_t;

endpackage

// ----- rtl/core/crpe_coef.sv -----
`timescale 1ns / 1ps
`include "catmull_rom_point_eval_macros.svh"
module crpe_coef import crpe_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	output logic   up_stall,
	input  knots_t up_beat,
	output logic   dn_valid,
	input  logic   dn_stall,
	output coef_t  cd_o [2],
	output coef_t  cc_o [2],
	output side_t  side_o
);

	coord_t p0 [2];
	coord_t p1 [2];
	coord_t p2 [2];
	coord_t p3 [2];
	coef_t  d12 [2];
	coef_t  cd_c [2];
	coef_t  cc_c [2];
	cb_t    cb_c [2];
	ca_t    ca_c [2];
	tpar_t  t_c;

	logic   v_s1;
	logic   rdy_s1;
	coef_t  cd_s1 [2];
	coef_t  cc_s1 [2];
	side_t  side_s1;

	// Lane 0 is x, lane 1 is y
	assign p0[0] = up_beat.p0_x;
	assign p0[1] = up_beat.p0_y;
	assign p1[0] = up_beat.p1_x;
	assign p1[1] = up_beat.p1_y;
	assign p2[0] = up_beat.p2_x;
	assign p2[1] = up_beat.p2_y;
	assign p3[0] = up_beat.p3_x;
	assign p3[1] = up_beat.p3_y;

	// Parameter above one is held at one
	assign t_c = (up_beat.param_t > T_ONE) ? T_ONE : up_beat.param_t;

	// Basis coefficients, shifts and adds only
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			d12[i]  = coef_t'(p1[i]) - coef_t'(p2[i]);
			cd_c[i] = coef_t'(p3[i]) - coef_t'(p0[i]) + d12[i] + (d12[i] <<< 1);
			cc_c[i] = (coef_t'(p0[i]) <<< 1) - (coef_t'(p1[i]) <<< 2) - coef_t'(p1[i])
				+ (coef_t'(p2[i]) <<< 2) - coef_t'(p3[i]);
			cb_c[i] = cb_t'(p2[i]) - cb_t'(p0[i]);
			ca_c[i] = {p1[i], 1'b1};
		end
	end

	// Stage handshake
	assign rdy_s1   = !v_s1 || !dn_stall;
	assign up_stall = !rdy_s1;
	assign dn_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			cd_s1        <= cd_c;
			cc_s1        <= cc_c;
			side_s1.t    <= t_c;
			side_s1.cb_x <= cb_c[0];
			side_s1.cb_y <= cb_c[1];
			side_s1.ca_x <= ca_c[0];
			side_s1.ca_y <= ca_c[1];
		end
	end

	assign cd_o   = cd_s1;
	assign cc_o   = cc_s1;
	assign side_o = side_s1;

	`CRPE_ASSERT_NEXT(a_t_clamped, up_valid && !up_stall && (up_beat.param_t > T_ONE), side_s1.t == T_ONE, "parameter above one not clamped")

endmodule

// ----- rtl/core/crpe_horner.sv -----
`timescale 1ns / 1ps
`include "catmull_rom_point_eval_macros.svh"
module crpe_horner import crpe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_stall,
	input  mul_t  acc_i [2],
	input  prod_t add_i [2],
	input  side_t side_i,
	output logic  dn_valid,
	input  logic  dn_stall,
	output prod_t sum_o [2],
	output side_t side_o
);

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic        [LO_W+T_W-1:0] pp_lo_c  [2];
	logic signed [HI_W+T_W-1:0] pp_hi_c  [2];
	logic        [LO_W+T_W-1:0] pp_lo_s1 [2];
	logic signed [HI_W+T_W-1:0] pp_hi_s1 [2];
	prod_t add_s1 [2];
	side_t side_s1;

	prod_t prod_c  [2];
	prod_t prod_s2 [2];
	prod_t add_s2  [2];
	side_t side_s2;

	prod_t sum_c  [2];
	prod_t sum_s3 [2];
	side_t side_s3;

	// Ready runs back from the output, so bubbles close up
	assign rdy_s3   = !v_s3 || !dn_stall;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_stall = !rdy_s1;
	assign dn_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Partial products: low half unsigned, high half signed, both times t
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			pp_lo_c[i] = {{T_W{1'b0}}, acc_i[i][LO_W-1:0]} * {{LO_W{1'b0}}, side_i.t};
			pp_hi_c[i] = $signed({{T_W{acc_i[i][MUL_W-1]}}, acc_i[i][MUL_W-1:LO_W]})
				* $signed({{HI_W{1'b0}}, side_i.t});
		end
	end

	// Recombine the halves
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			prod_c[i] = (prod_t'(pp_hi_s1[i]) <<< LO_W)
				+ prod_t'($signed({1'b0, pp_lo_s1[i]}));
		end
	end

	// Add the next coefficient term
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			sum_c[i] = prod_s2[i] + add_s2[i];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			pp_lo_s1 <= pp_lo_c;
			pp_hi_s1 <= pp_hi_c;
			add_s1   <= add_i;
			side_s1  <= side_i;
		end
		if (rdy_s2 && v_s1) begin
			prod_s2 <= prod_c;
			add_s2  <= add_s1;
			side_s2 <= side_s1;
		end
		if (rdy_s3 && v_s2) begin
			sum_s3  <= sum_c;
			side_s3 <= side_s2;
		end
	end

	assign sum_o  = sum_s3;
	assign side_o = side_s3;

	`CRPE_ASSERT_NEXT(a_beat_taken, up_valid && !up_stall, v_s1, "accepted beat missing from first stage")
	`CRPE_ASSERT_NEXT(a_hold_x, v_s3 && dn_stall, v_s3 && $stable(sum_s3[0]), "stalled x sum changed")
	`CRPE_ASSERT_NEXT(a_hold_y, v_s3 && dn_stall, v_s3 && $stable(sum_s3[1]), "stalled y sum changed")

endmodule

// ----- rtl/core/crpe_round.sv -----
`timescale 1ns / 1ps
`include "catmull_rom_point_eval_macros.svh"
module crpe_round import crpe_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	output logic   up_stall,
	input  prod_t  sum_i [2],
	output logic   dn_valid,
	input  logic   dn_stall,
	output curve_t beat_o
);

	logic signed [RND_W-1:0]       rnd   [2];
	logic        [RND_W-COORD_W:0] top   [2];
	logic                          ovf   [2];
	coord_t                        sat_c [2];

	logic   v_s1;
	logic   rdy_s1;
	curve_t beat_s1;

	// Half was folded into the constant term; the shift floors.
	// Out of range when the sign bit and the bits above it are not all equal.
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rnd[i] = sum_i[i][PROD_W-1:SHIFT];
			top[i] = rnd[i][RND_W-1:COORD_W-1];
			ovf[i] = !((&top[i]) || !(|top[i]));
			if (ovf[i]) begin
				sat_c[i] = rnd[i][RND_W-1] ? COORD_MIN : COORD_MAX;
			end else begin
				sat_c[i] = rnd[i][COORD_W-1:0];
			end
		end
	end

	assign rdy_s1   = !v_s1 || !dn_stall;
	assign up_stall = !rdy_s1;
	assign dn_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			beat_s1.curve_x   <= sat_c[0];
			beat_s1.curve_y   <= sat_c[1];
			beat_s1.saturated <= ovf[0] || ovf[1];
		end
	end

	assign beat_o = beat_s1;

	`CRPE_ASSERT_SAME(a_sat_at_bound, v_s1 && beat_s1.saturated, (beat_s1.curve_x == COORD_MAX) || (beat_s1.curve_x == COORD_MIN) || (beat_s1.curve_y == COORD_MAX) || (beat_s1.curve_y == COORD_MIN), "saturated flag without a clipped coordinate")

endmodule

// ----- rtl/core/catmull_rom_point_eval.sv -----
`timescale 1ns / 1ps
// Uniform Catmull-Rom point evaluator.
// knots channel: four signed control points and t (unsigned Q1.16, values
// above one are treated as one). curve channel: the point on the segment
// from P1 to P2, rounded to nearest (halves upward), saturated to signed
// 16 bits, with a flag when either axis was clipped.
// Both channels move a beat when valid is high and stall is low.
// Pipeline: one coefficient stage, three Horner steps of three stages each,
// one round and clip stage, between an accepted knots beat and its curve
// beat. Throughput: one beat per cycle while curve_stall is low; each Horner
// step holds one 28x17 partial-product multiplier pair per axis.
// Each stage has its own valid bit and takes a new beat whenever it is
// empty or its neighbour downstream moves, so a stall on curve fills the
// empty stages first and knots_stall only rises once the pipeline is full.
// Nothing is lost or repeated under stall.
// Reset clears all valid bits; the data registers are not reset.
module catmull_rom_point_eval import crpe_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   knots_valid,
	output logic   knots_stall,
	input  knots_t knots,
	output logic   curve_valid,
	input  logic   curve_stall,
	output curve_t curve
);

	logic  c_valid, c_stall;
	logic  h1_valid, h1_stall;
	logic  h2_valid, h2_stall;
	logic  h3_valid, h3_stall;

	coef_t cd [2];
	coef_t cc [2];
	side_t side_c, side_h1, side_h2;

	mul_t  acc1 [2];
	mul_t  acc2 [2];
	mul_t  acc3 [2];
	prod_t add1 [2];
	prod_t add2 [2];
	prod_t add3 [2];
	prod_t sum1 [2];
	prod_t sum2 [2];
	prod_t sum3 [2];

	crpe_coef u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (knots_valid),
		.up_stall (knots_stall),
		.up_beat  (knots),
		.dn_valid (c_valid),
		.dn_stall (c_stall),
		.cd_o     (cd),
		.cc_o     (cc),
		.side_o   (side_c)
	);

	// Horner operands: accumulator narrowed to its bound, next term aligned
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			acc1[i] = mul_t'(cd[i]);
			add1[i] = prod_t'(cc[i]) <<< T_FRAC;
			acc2[i] = mul_t'(sum1[i]);
			acc3[i] = mul_t'(sum2[i]);
		end
		add2[0] = prod_t'(side_h1.cb_x) <<< (2 * T_FRAC);
		add2[1] = prod_t'(side_h1.cb_y) <<< (2 * T_FRAC);
		add3[0] = prod_t'(side_h2.ca_x) <<< (3 * T_FRAC);
		add3[1] = prod_t'(side_h2.ca_y) <<< (3 * T_FRAC);
	end

	crpe_horner u_step1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (c_valid),
		.up_stall (c_stall),
		.acc_i    (acc1),
		.add_i    (add1),
		.side_i   (side_c),
		.dn_valid (h1_valid),
		.dn_stall (h1_stall),
		.sum_o    (sum1),
		.side_o   (side_h1)
	);

	crpe_horner u_step2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (h1_valid),
		.up_stall (h1_stall),
		.acc_i    (acc2),
		.add_i    (add2),
		.side_i   (side_h1),
		.dn_valid (h2_valid),
		.dn_stall (h2_stall),
		.sum_o    (sum2),
		.side_o   (side_h2)
	);

	crpe_horner u_step3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (h2_valid),
		.up_stall (h2_stall),
		.acc_i    (acc3),
		.add_i    (add3),
		.side_i   (side_h2),
		.dn_valid (h3_valid),
		.dn_stall (h3_stall),
		.sum_o    (sum3),
		.side_o   ()
	);

	crpe_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (h3_valid),
		.up_stall (h3_stall),
		.sum_i    (sum3),
		.dn_valid (curve_valid),
		.dn_stall (curve_stall),
		.beat_o   (curve)
	);

endmodule
